// ===== hw/rtl/pfa_pkg.sv =====
// Shared types and constants for the page frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int ADDR_BITS   = 48;
    localparam int PAGE_SHIFT  = 12;
    localparam int MAX_FRAMES  = 4096;
    localparam int IDX_BITS    = $clog2(MAX_FRAMES);
    localparam int CNT_BITS    = IDX_BITS + 1;
    // frame numbers, one bit wider so the page just past the top still fits
    localparam int FRAME_BITS  = ADDR_BITS - PAGE_SHIFT + 1;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_SIZE = 2'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_ALLOC  = 2'd0,
        STAT_OOM    = 2'd1,
        STAT_FREED  = 2'd2,
        STAT_REJECT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_REBUILD
    } t_state;

    typedef struct packed {
        logic                 func;
        logic [ADDR_BITS-1:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0] frame_addr;
        logic [1:0]           status;
        logic [CNT_BITS-1:0]  frames_free;
        logic [CNT_BITS-1:0]  frames_used;
    } t_rsp;

endpackage

// ===== hw/rtl/pfa_req_if.sv =====
// Request channel interface: valid, ready and request payload.
`timescale 1ns / 1ps

interface pfa_req_if;
    logic        valid;
    logic        ready;
    pfa_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pfa_rsp_if.sv =====
// Response channel interface: valid, ready and result payload.
`timescale 1ns / 1ps

interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    pfa_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/page_frame_allocator.sv =====
// Page frame allocator: bump cursor plus LIFO free list held in a link RAM.
// Free and bump allocation go straight to the result register; a pop from the
// free list waits in S_POP for the registered read of the link RAM first.
// One item in flight: no request is taken in S_POP, or while a result waits.
// Reset and each write to the base or size register start a rebuild of the
// region state from the registers, taking no requests. Link RAM not cleared.
`timescale 1ns / 1ps

module page_frame_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [pfa_pkg::ADDR_BITS-1:0]       i_cfg_data,
    pfa_req_if.sink                             i_req,
    pfa_rsp_if.source                           o_rsp
);

    localparam int AB = pfa_pkg::ADDR_BITS;
    localparam int PS = pfa_pkg::PAGE_SHIFT;
    localparam int FB = pfa_pkg::FRAME_BITS;
    localparam int IB = pfa_pkg::IDX_BITS;
    localparam int CB = pfa_pkg::CNT_BITS;

    localparam logic [CB-1:0] MAX_CNT = CB'(pfa_pkg::MAX_FRAMES);
    localparam logic [FB-1:0] TOP_FRAME = FB'(1) << (AB - PS);

    // configuration and region state
    logic [AB-1:0]  r_region_base;
    logic [AB-1:0]  r_region_size;
    logic [FB-1:0]  r_first_frame,  n_first_frame;
    logic [CB-1:0]  r_region_frames, n_region_frames;
    logic [CB-1:0]  r_bump_index,   n_bump_index;
    logic [CB-1:0]  r_list_head,    n_list_head;
    logic [CB-1:0]  r_free_count,   n_free_count;
    logic [CB-1:0]  r_used_count,   n_used_count;

    pfa_pkg::t_state r_state, n_state;

    logic           r_out_valid, n_out_valid;
    pfa_pkg::t_rsp  r_rsp, n_rsp;

    // link RAM
    logic [CB-1:0]  link_store [pfa_pkg::MAX_FRAMES];
    logic           mem_we;
    logic [IB-1:0]  mem_wr_idx;
    logic [IB-1:0]  mem_rd_idx;
    logic [CB-1:0]  r_link_q;

    logic cfg_hit;
    logic req_fire;
    logic rsp_fire;
    logic in_ready;

    // rebuild arithmetic
    logic [FB-1:0]  rb_lo;
    logic [AB:0]    rb_sum;
    logic [FB-1:0]  rb_hi;
    logic [FB-1:0]  rb_n;

    // free checks
    logic [FB-1:0]  fr_frame;
    logic [FB-1:0]  fr_end;
    logic [FB-1:0]  fr_off;
    logic           fr_ok;

    // allocation address
    logic [IB-1:0]  al_idx;
    logic [FB-1:0]  al_frame;

    assign cfg_hit  = i_cfg_we && (i_cfg_idx == pfa_pkg::CFG_REGION_BASE ||
                                   i_cfg_idx == pfa_pkg::CFG_REGION_SIZE);
    assign req_fire = i_req.valid && in_ready;
    assign rsp_fire = r_out_valid && o_rsp.ready;

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (req_fire && i_req.payload.func == pfa_pkg::FUNC_ALLOC &&
                    r_list_head != '0) begin
                    n_state = pfa_pkg::S_POP;
                end
            end
            pfa_pkg::S_POP:     n_state = pfa_pkg::S_IDLE;
            pfa_pkg::S_REBUILD: n_state = pfa_pkg::S_IDLE;
            default:            n_state = pfa_pkg::S_IDLE;
        endcase
        if (cfg_hit) begin
            n_state = pfa_pkg::S_REBUILD;
        end
    end

    always_comb begin
        in_ready = 1'b0;
        case (r_state)
            pfa_pkg::S_IDLE:    in_ready = !r_out_valid || o_rsp.ready;
            pfa_pkg::S_POP:     in_ready = 1'b0;
            pfa_pkg::S_REBUILD: in_ready = 1'b0;
            default:            in_ready = 1'b0;
        endcase
    end

    // ---------------- region rebuild ----------------
    always_comb begin
        rb_lo  = FB'(r_region_base[AB-1:PS]) + FB'(r_region_base[PS-1:0] != '0);
        if (rb_lo == '0) begin
            rb_lo = FB'(1);
        end
        rb_sum = {1'b0, r_region_base} + {1'b0, r_region_size};
        rb_hi  = rb_sum[AB:PS];
        if (rb_hi > TOP_FRAME) begin
            rb_hi = TOP_FRAME;
        end
        rb_n = (rb_hi > rb_lo) ? (rb_hi - rb_lo) : '0;
        if (rb_n > FB'(pfa_pkg::MAX_FRAMES)) begin
            rb_n = FB'(pfa_pkg::MAX_FRAMES);
        end
    end

    // ---------------- free address checks ----------------
    always_comb begin
        fr_frame = FB'(i_req.payload.free_addr[AB-1:PS]);
        fr_end   = r_first_frame + FB'(r_bump_index);
        fr_off   = fr_frame - r_first_frame;
        fr_ok    = (i_req.payload.free_addr != '0) &&
                   (i_req.payload.free_addr[PS-1:0] == '0) &&
                   (fr_frame >= r_first_frame) &&
                   (fr_frame < fr_end);
    end

    // pop reads the entry under the current head; head holds index plus one
    assign mem_rd_idx = IB'(r_list_head - CB'(1));

    // ---------------- datapath ----------------
    always_comb begin
        n_first_frame   = r_first_frame;
        n_region_frames = r_region_frames;
        n_bump_index    = r_bump_index;
        n_list_head     = r_list_head;
        n_free_count    = r_free_count;
        n_used_count    = r_used_count;
        n_rsp           = r_rsp;
        n_out_valid     = r_out_valid && !o_rsp.ready;
        mem_we          = 1'b0;
        mem_wr_idx      = IB'(fr_off);
        al_idx          = mem_rd_idx;
        if (r_state == pfa_pkg::S_IDLE && r_list_head == '0) begin
            al_idx = IB'(r_bump_index);
        end
        al_frame = r_first_frame + FB'(al_idx);

        if (r_state == pfa_pkg::S_REBUILD) begin
            n_first_frame   = rb_lo;
            n_region_frames = CB'(rb_n);
            n_bump_index    = '0;
            n_list_head     = '0;
            n_free_count    = CB'(rb_n);
            n_used_count    = '0;
        end else if (r_state == pfa_pkg::S_POP) begin
            n_list_head            = r_link_q;
            n_free_count           = (r_free_count != '0) ? r_free_count - CB'(1)
                                                          : r_free_count;
            n_used_count           = (r_used_count < MAX_CNT) ? r_used_count + CB'(1)
                                                              : r_used_count;
            n_rsp.frame_addr       = {al_frame[AB-PS-1:0], {PS{1'b0}}};
            n_rsp.status           = pfa_pkg::STAT_ALLOC;
            n_rsp.frames_free      = n_free_count;
            n_rsp.frames_used      = n_used_count;
            n_out_valid            = 1'b1;
        end else if (req_fire) begin
            if (i_req.payload.func == pfa_pkg::FUNC_ALLOC) begin
                if (r_list_head == '0) begin
                    n_rsp.frame_addr = '0;
                    n_rsp.status     = pfa_pkg::STAT_OOM;
                    if (r_bump_index < r_region_frames) begin
                        n_bump_index     = r_bump_index + CB'(1);
                        n_free_count     = (r_free_count != '0) ?
                                           r_free_count - CB'(1) : r_free_count;
                        n_used_count     = (r_used_count < MAX_CNT) ?
                                           r_used_count + CB'(1) : r_used_count;
                        n_rsp.frame_addr = {al_frame[AB-PS-1:0], {PS{1'b0}}};
                        n_rsp.status     = pfa_pkg::STAT_ALLOC;
                    end
                    n_rsp.frames_free = n_free_count;
                    n_rsp.frames_used = n_used_count;
                    n_out_valid       = 1'b1;
                end
            end else begin
                n_rsp.frame_addr = '0;
                n_rsp.status     = pfa_pkg::STAT_REJECT;
                if (fr_ok) begin
                    mem_we       = 1'b1;
                    n_list_head  = CB'(mem_wr_idx) + CB'(1);
                    n_free_count = (r_free_count < MAX_CNT) ?
                                   r_free_count + CB'(1) : r_free_count;
                    n_used_count = (r_used_count != '0) ?
                                   r_used_count - CB'(1) : r_used_count;
                    n_rsp.status = pfa_pkg::STAT_FREED;
                end
                n_rsp.frames_free = n_free_count;
                n_rsp.frames_used = n_used_count;
                n_out_valid       = 1'b1;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pfa_pkg::S_REBUILD;
            r_out_valid   <= 1'b0;
            r_region_base <= '0;
            r_region_size <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == pfa_pkg::CFG_REGION_BASE) begin
                r_region_base <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == pfa_pkg::CFG_REGION_SIZE) begin
                r_region_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_frame   <= n_first_frame;
        r_region_frames <= n_region_frames;
        r_bump_index    <= n_bump_index;
        r_list_head     <= n_list_head;
        r_free_count    <= n_free_count;
        r_used_count    <= n_used_count;
        r_rsp           <= n_rsp;
    end

    // link RAM: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            link_store[mem_wr_idx] <= r_list_head;
        end
        r_link_q <= link_store[mem_rd_idx];
    end

    // ---------------- assertions ----------------
    a_pop_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfa_pkg::S_POP |-> !r_out_valid)
        else $error("pop cycle with a result still pending");

    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire && !cfg_hit |=> (r_out_valid || r_state == pfa_pkg::S_POP))
        else $error("accepted request produced neither result nor pop");

    a_bump_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != pfa_pkg::S_REBUILD |-> r_bump_index <= r_region_frames)
        else $error("bump cursor beyond region");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(req_fire) || $past(r_state == pfa_pkg::S_POP)))
        else $error("result appeared without a request");

endmodule

// ===== verif/page_frame_allocator_test.sv =====
// Self-checking testbench for the page frame allocator: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module page_frame_allocator_test;

    localparam int          PAGE_BYTES   = 1 << pfa_pkg::PAGE_SHIFT;
    localparam logic [63:0] TOP_FRAME    = 64'd1 << (pfa_pkg::ADDR_BITS - pfa_pkg::PAGE_SHIFT);
    localparam int          RANDOM_ITEMS = 600;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          LONG_HOLD    = 60;
    localparam int          MAX_REPORTS  = 100;

    // register indexes that map to nothing
    localparam logic [pfa_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [pfa_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_3 = 2'd3;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_cfg_we   = 1'b0;
    logic [pfa_pkg::CFG_IDX_BITS-1:0] i_cfg_idx  = '0;
    logic [pfa_pkg::ADDR_BITS-1:0]    i_cfg_data = '0;

    pfa_req_if req_if ();
    pfa_rsp_if rsp_if ();

    page_frame_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // allocator state as the block should hold it
    logic [63:0] cfg_base;
    logic [63:0] cfg_size;
    logic [63:0] region_lo;
    int unsigned frame_total;
    int unsigned cursor;
    int unsigned stack_top;      // free-list head, frame index plus one, 0 = empty
    int unsigned next_link [pfa_pkg::MAX_FRAMES];
    int unsigned n_free;
    int unsigned n_used;

    pfa_pkg::t_req                 pending_req [$];
    pfa_pkg::t_rsp                 expected_rsp [$];
    logic [pfa_pkg::ADDR_BITS-1:0] handed_out [$];   // frames believed to be allocated

    int items_queued = 0;
    int items_taken  = 0;
    int rsp_seen     = 0;
    int fail_count   = 0;
    int req_wait     = 0;
    int rsp_wait     = 0;
    int quiet_cycles = 0;
    bit req_burst    = 1'b0;
    bit rsp_burst    = 1'b0;

    function automatic void reload_region();
        logic [63:0] lo;
        logic [63:0] hi;
        lo = (cfg_base + 64'(PAGE_BYTES - 1)) >> pfa_pkg::PAGE_SHIFT;
        hi = (cfg_base + cfg_size) >> pfa_pkg::PAGE_SHIFT;
        if (lo == 0) lo = 1;         // page zero is never handed out
        if (hi > TOP_FRAME) hi = TOP_FRAME;
        frame_total = 0;
        if (hi > lo) begin
            frame_total = (hi - lo > pfa_pkg::MAX_FRAMES) ? pfa_pkg::MAX_FRAMES
                                                          : int'(hi - lo);
        end
        region_lo = lo;
        cursor    = 0;
        stack_top = 0;
        n_free    = frame_total;
        n_used    = 0;
        handed_out.delete();
    endfunction

    function automatic pfa_pkg::t_rsp serve_request(pfa_pkg::t_req rq);
        pfa_pkg::t_rsp rs;
        int unsigned   idx;
        bit            got;
        logic [63:0]   a;
        logic [63:0]   f;
        rs  = '0;
        got = 1'b0;
        idx = 0;
        if (rq.func == pfa_pkg::FUNC_ALLOC) begin
            if (stack_top != 0) begin
                idx       = stack_top - 1;
                stack_top = next_link[idx];
                got       = 1'b1;
            end else if (cursor < frame_total) begin
                idx    = cursor;
                cursor = cursor + 1;
                got    = 1'b1;
            end
            if (got) begin
                rs.frame_addr = pfa_pkg::ADDR_BITS'((region_lo + idx) << pfa_pkg::PAGE_SHIFT);
                rs.status     = pfa_pkg::STAT_ALLOC;
                if (n_free > 0) n_free--;
                if (n_used < pfa_pkg::MAX_FRAMES) n_used++;
                handed_out.push_back(rs.frame_addr);
            end else begin
                rs.status = pfa_pkg::STAT_OOM;
            end
        end else begin
            a = 64'(rq.free_addr);
            f = a >> pfa_pkg::PAGE_SHIFT;
            if (a == 0 || a[pfa_pkg::PAGE_SHIFT-1:0] != 0 || f < region_lo ||
                f >= region_lo + cursor) begin
                rs.status = pfa_pkg::STAT_REJECT;
            end else begin
                idx            = int'(f - region_lo);
                next_link[idx] = stack_top;
                stack_top      = idx + 1;
                if (n_free < pfa_pkg::MAX_FRAMES) n_free++;
                if (n_used > 0) n_used--;
                rs.status = pfa_pkg::STAT_FREED;
            end
        end
        rs.frames_free = pfa_pkg::CNT_BITS'(n_free);
        rs.frames_used = pfa_pkg::CNT_BITS'(n_used);
        return rs;
    endfunction

    function automatic void report_field(string what, logic [63:0] want, logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    endfunction

    function automatic void check_response(pfa_pkg::t_rsp got);
        pfa_pkg::t_rsp want;
        if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: response with nothing outstanding, actual %h", $time, got);
            return;
        end
        want = expected_rsp.pop_front();
        if (got.frame_addr !== want.frame_addr)
            report_field("frame_addr", 64'(want.frame_addr), 64'(got.frame_addr));
        if (got.status !== want.status)
            report_field("status", 64'(want.status), 64'(got.status));
        if (got.frames_free !== want.frames_free)
            report_field("frames_free", 64'(want.frames_free), 64'(got.frames_free));
        if (got.frames_used !== want.frames_used)
            report_field("frames_used", 64'(want.frames_used), 64'(got.frames_used));
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [pfa_pkg::ADDR_BITS-1:0] random_addr48();
        return pfa_pkg::ADDR_BITS'({$urandom, $urandom});
    endfunction

    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
    end

    // request driver
    always @(posedge i_clk) begin : feed_req
        int gap;
        if (!i_rst_n) begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            req_wait       <= 0;
        end else if (!req_if.valid || req_if.ready) begin
            gap = req_wait;
            if (req_if.valid) begin
                // transfer at this edge
                expected_rsp.push_back(serve_request(req_if.payload));
                items_taken++;
                gap = draw_gap(req_burst);
            end
            if (gap == 0 && pending_req.size() != 0) begin
                req_if.valid   <= 1'b1;
                req_if.payload <= pending_req.pop_front();
                req_wait       <= 0;
            end else begin
                req_if.valid <= 1'b0;
                req_wait     <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // response monitor with receiver stalls
    always @(posedge i_clk) begin : take_rsp
        int hold;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_wait     <= 0;
        end else begin
            hold = rsp_wait;
            if (rsp_if.valid && rsp_if.ready) begin
                check_response(rsp_if.payload);
                rsp_seen++;
                // now and then hold off long enough to back up the request side
                hold = (rsp_seen % 300 == 120) ? LONG_HOLD : draw_gap(rsp_burst);
            end
            if (hold == 0) begin
                rsp_if.ready <= 1'b1;
                rsp_wait     <= 0;
            end else begin
                rsp_if.ready <= 1'b0;
                rsp_wait     <= hold - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_item(logic func, logic [pfa_pkg::ADDR_BITS-1:0] addr);
        pfa_pkg::t_req rq;
        rq.func      = func;
        rq.free_addr = addr;
        while (pending_req.size() > 3) @(posedge i_clk);
        pending_req.push_back(rq);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || expected_rsp.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pfa_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [pfa_pkg::ADDR_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == pfa_pkg::CFG_REGION_BASE) begin
            cfg_base = 64'(value);
            reload_region();
        end else if (idx == pfa_pkg::CFG_REGION_SIZE) begin
            cfg_size = 64'(value);
            reload_region();
        end
    endtask

    initial begin : stimulus
        logic                          func;
        logic [pfa_pkg::ADDR_BITS-1:0] addr;
        logic [pfa_pkg::ADDR_BITS-1:0] base_val;
        logic [pfa_pkg::ADDR_BITS-1:0] size_val;
        int                            phase;
        int                            n;
        int                            k;
        int                            r;
        int                            random_sent;

        cfg_base = '0;
        cfg_size = '0;
        reload_region();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty region straight out of reset
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        push_item(pfa_pkg::FUNC_FREE, '0);
        push_item(pfa_pkg::FUNC_FREE, 48'h1000);
        wait_idle();

        // misaligned base: frames 2..5
        write_reg(pfa_pkg::CFG_REGION_BASE, 48'h1234);
        write_reg(pfa_pkg::CFG_REGION_SIZE, 48'h5000);
        repeat (5) push_item(pfa_pkg::FUNC_ALLOC, random_addr48());
        push_item(pfa_pkg::FUNC_FREE, '0);
        push_item(pfa_pkg::FUNC_FREE, 48'h2001);
        push_item(pfa_pkg::FUNC_FREE, 48'h1000);
        push_item(pfa_pkg::FUNC_FREE, 48'h6000);
        push_item(pfa_pkg::FUNC_FREE, 48'h3000);
        push_item(pfa_pkg::FUNC_FREE, 48'h2000);
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        wait_idle();
        write_reg(CFG_UNUSED_2, '1);
        write_reg(CFG_UNUSED_3, 48'h5555_5555_5555);
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        // double free makes the list loop on one frame
        push_item(pfa_pkg::FUNC_FREE, 48'h4000);
        push_item(pfa_pkg::FUNC_FREE, 48'h4000);
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        push_item(pfa_pkg::FUNC_FREE, '1);
        wait_idle();

        // full-size region, counts pushed into saturation
        write_reg(pfa_pkg::CFG_REGION_BASE, '0);
        write_reg(pfa_pkg::CFG_REGION_SIZE, '1);
        push_item(pfa_pkg::FUNC_ALLOC, '0);
        repeat (3) push_item(pfa_pkg::FUNC_FREE, 48'h1000);

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                base_val = '1;
                size_val = '1;
            end else if (phase == 1) begin
                // four frames just under the top of the address space
                base_val = 48'hFFFF_FFFF_BFFB;
                size_val = '1;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        base_val = pfa_pkg::ADDR_BITS'($urandom_range(0, 64) * PAGE_BYTES);
                        if ($urandom_range(0, 1)) begin
                            base_val[pfa_pkg::PAGE_SHIFT-1:0] =
                                pfa_pkg::PAGE_SHIFT'($urandom);
                        end
                        size_val = pfa_pkg::ADDR_BITS'($urandom_range(0, 24) * PAGE_BYTES
                                             + $urandom_range(0, PAGE_BYTES - 1));
                    end
                    1: begin
                        base_val = random_addr48();
                        size_val = pfa_pkg::ADDR_BITS'($urandom_range(0, 40) * PAGE_BYTES
                                             + $urandom_range(0, PAGE_BYTES - 1));
                    end
                    2: begin
                        base_val = random_addr48();
                        size_val = random_addr48();
                    end
                    default: begin
                        base_val = '0;
                        size_val = pfa_pkg::ADDR_BITS'($urandom_range(0, 12) * PAGE_BYTES);
                    end
                endcase
            end
            if (phase < 2 || $urandom_range(0, 5) != 0) begin
                if ($urandom_range(0, 1)) begin
                    write_reg(pfa_pkg::CFG_REGION_BASE, base_val);
                    write_reg(pfa_pkg::CFG_REGION_SIZE, size_val);
                end else begin
                    write_reg(pfa_pkg::CFG_REGION_SIZE, size_val);
                    write_reg(pfa_pkg::CFG_REGION_BASE, base_val);
                end
            end else if ($urandom_range(0, 1)) begin
                write_reg(pfa_pkg::CFG_REGION_BASE, base_val);
            end else begin
                write_reg(pfa_pkg::CFG_REGION_SIZE, size_val);
            end

            n = (phase < 2) ? 20 : $urandom_range(30, 70);
            for (int j = 0; j < n; j++) begin
                if (j == n / 2 && $urandom_range(0, 3) == 0) begin
                    // writes to unmapped indexes must leave the state alone
                    wait_idle();
                    write_reg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                              random_addr48());
                end
                func = pfa_pkg::FUNC_ALLOC;
                addr = random_addr48();
                r    = $urandom_range(0, 99);
                if (r >= 50) begin
                    func = pfa_pkg::FUNC_FREE;
                    if (r < 85 && handed_out.size() != 0) begin
                        k    = $urandom_range(0, handed_out.size() - 1);
                        addr = handed_out[k];
                        // leave a few in the pool so they get freed twice
                        if ($urandom_range(0, 9) != 0) handed_out.delete(k);
                    end else begin
                        case ($urandom_range(0, 4))
                            0: addr = '0;
                            1: addr = pfa_pkg::ADDR_BITS'(
                                          ((region_lo + $urandom_range(0, cursor))
                                           << pfa_pkg::PAGE_SHIFT)
                                          | $urandom_range(1, PAGE_BYTES - 1));
                            2: addr = pfa_pkg::ADDR_BITS'((region_lo - 1)
                                                          << pfa_pkg::PAGE_SHIFT);
                            3: addr = pfa_pkg::ADDR_BITS'(
                                          (region_lo + cursor + $urandom_range(0, 3))
                                          << pfa_pkg::PAGE_SHIFT);
                            default: addr = random_addr48();
                        endcase
                    end
                end
                push_item(func, addr);
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
